FILE: hw/rtl/assert_macros.svh
// assertion macros of the rtl, included by the deframer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lpfd_pkg.sv
// types and constants of the length prefixed frame deframer
`timescale 1ns / 1ps

package lpfd_pkg;

    // field widths of the channels
    localparam int CMD_W    = 2;
    localparam int DATA_W   = 8;
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 2;
    localparam int PLEN_W   = 11;
    localparam int LEN_W    = 32;

    // frame format
    localparam int PAYLOAD_MAX  = 1024;
    localparam int HEADER_BYTES = 5;

    // reset value of the expected kind byte
    localparam logic [DATA_W-1:0] REQ_KIND_RST = 8'd1;
    // kind reported while no frame is held
    localparam logic [DATA_W-1:0] KIND_NONE    = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEED_MORE = 2'd0,
        ST_DROP      = 2'd1,
        ST_READY     = 2'd2,
        ST_DONE      = 2'd3
    } t_status;

    // registered result fields, data byte comes from the store
    typedef struct packed {
        t_status             status;
        logic                read_ok;
        logic [PLEN_W-1:0]   payload_length;
        logic [DATA_W-1:0]   kind_out;
    } t_result;

endpackage

FILE: hw/rtl/lpfd_in_if.sv
// input channel of the deframer: command beats
`timescale 1ns / 1ps

interface lpfd_in_if;
    logic                         valid;
    logic                         ready;
    logic [lpfd_pkg::CMD_W-1:0]   cmd;
    logic [lpfd_pkg::DATA_W-1:0]  data_in;
    logic [lpfd_pkg::IDX_W-1:0]   read_index;

    modport source (output valid, output cmd, output data_in, output read_index,
                    input ready);
    modport sink   (input valid, input cmd, input data_in, input read_index,
                    output ready);
endinterface

FILE: hw/rtl/lpfd_out_if.sv
// output channel of the deframer: result beats
`timescale 1ns / 1ps

interface lpfd_out_if;
    logic                           valid;
    logic                           ready;
    logic [lpfd_pkg::STATUS_W-1:0]  status;
    logic [lpfd_pkg::DATA_W-1:0]    data_out;
    logic                           read_ok;
    logic [lpfd_pkg::PLEN_W-1:0]    payload_length;
    logic [lpfd_pkg::DATA_W-1:0]    kind_out;

    modport source (output valid, output status, output data_out, output read_ok,
                    output payload_length, output kind_out, input ready);
    modport sink   (input valid, input status, input data_out, input read_ok,
                    input payload_length, input kind_out, output ready);
endinterface

FILE: hw/rtl/lpfd_store.sv
// payload byte store: one write port, one registered read port
`timescale 1ns / 1ps

module lpfd_store #(
    parameter int P_DEPTH  = lpfd_pkg::PAYLOAD_MAX,
    parameter int P_ADDR_W = 10
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [P_ADDR_W-1:0]         i_wr_addr,
    input  logic [lpfd_pkg::DATA_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [P_ADDR_W-1:0]         i_rd_addr,
    output logic [lpfd_pkg::DATA_W-1:0] o_rd_data
);

    logic [lpfd_pkg::DATA_W-1:0] r_mem [P_DEPTH];
    logic [lpfd_pkg::DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/length_prefixed_frame_deframer.sv
// top level of the length prefixed frame deframer
// Usage:
//   i_in carries one command beat per handshake: push a stream byte, read a
//   stored payload byte by index, or clear the frame. A frame is a kind byte
//   equal to the request kind, a 4-byte big-endian length, then the payload.
//   o_out carries exactly one result beat per command: status, read byte,
//   read flag, decoded length and the kind byte of the held frame.
//   i_cfg_we / i_cfg_wdata set the expected kind byte; write it while idle.
// Timing:
//   a taken beat waits in the input register and moves into the result
//   register when the output is free or taken. One beat per cycle is sustained
//   while o_out.ready holds, set by one frame state pass and store access per beat.
// Reset:
//   synchronous, active low; the frame is emptied, both stages are emptied,
//   the request kind returns to 1. The store needs no clearing pass.
// Stall:
//   a stalled result holds in the output register; one more beat waits in the
//   input register, then i_in.ready drops until the result is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module length_prefixed_frame_deframer #(
    parameter int P_PAYLOAD_MAX = lpfd_pkg::PAYLOAD_MAX
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lpfd_pkg::DATA_W-1:0] i_cfg_wdata,
    lpfd_in_if.sink                     i_in,
    lpfd_out_if.source                  o_out
);

    localparam int HDR     = lpfd_pkg::HEADER_BYTES;
    localparam int LIMIT   = HDR + P_PAYLOAD_MAX;
    localparam int FILL_W  = $clog2(LIMIT + 1);
    localparam int ADDR_W  = (P_PAYLOAD_MAX > 1) ? $clog2(P_PAYLOAD_MAX) : 1;
    localparam int CMP_W   = (FILL_W > lpfd_pkg::IDX_W) ? FILL_W : lpfd_pkg::IDX_W;
    localparam int LEN_W   = lpfd_pkg::LEN_W;
    localparam int DATA_W  = lpfd_pkg::DATA_W;
    localparam int PLEN_W  = lpfd_pkg::PLEN_W;

    // configuration
    logic [DATA_W-1:0]            r_req_kind;

    // input stage
    logic                         r_in_valid;
    logic [lpfd_pkg::CMD_W-1:0]   r_in_cmd;
    logic [DATA_W-1:0]            r_in_data;
    logic [lpfd_pkg::IDX_W-1:0]   r_in_idx;

    // frame state
    logic [FILL_W-1:0]            r_fill, n_fill;
    logic [DATA_W-1:0]            r_kind, n_kind;
    logic [LEN_W-1:0]             r_len,  n_len;

    // result stage
    logic                         r_out_valid;
    lpfd_pkg::t_result            r_res, n_res;

    // store access
    logic                         wr_en, rd_en;
    logic [ADDR_W-1:0]            wr_addr, rd_addr;
    logic [DATA_W-1:0]            rd_data;

    logic                         adv;
    logic                         in_take;
    logic                         frame_clear;
    lpfd_pkg::t_status            status;
    logic                         read_ok;

    // handshake of both stages
    assign adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || adv;

    // per-beat frame logic
    always_comb begin
        n_fill      = r_fill;
        n_kind      = r_kind;
        n_len       = r_len;
        status      = lpfd_pkg::ST_DONE;
        read_ok     = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        frame_clear = 1'b0;
        case (lpfd_pkg::t_cmd'(r_in_cmd))
            lpfd_pkg::CMD_PUSH: begin
                if (r_fill >= FILL_W'(LIMIT)) begin
                    frame_clear = 1'b1;
                    status      = lpfd_pkg::ST_DROP;
                end else begin
                    if (r_fill == '0) begin
                        n_kind = r_in_data;
                    end else if (r_fill < FILL_W'(HDR)) begin
                        n_len = {r_len[LEN_W-DATA_W-1:0], r_in_data};
                    end else begin
                        wr_en = 1'b1;
                    end
                    n_fill = r_fill + FILL_W'(1);
                    if (r_fill == '0) begin
                        if (r_in_data != r_req_kind) begin
                            frame_clear = 1'b1;
                            status      = lpfd_pkg::ST_DROP;
                        end else begin
                            status = lpfd_pkg::ST_NEED_MORE;
                        end
                    end else if (r_fill < FILL_W'(HDR - 1)) begin
                        status = lpfd_pkg::ST_NEED_MORE;
                    end else if (n_len > LEN_W'(P_PAYLOAD_MAX)) begin
                        frame_clear = 1'b1;
                        status      = lpfd_pkg::ST_DROP;
                    end else if ((LEN_W'(r_fill) - LEN_W'(HDR - 1)) < n_len) begin
                        status = lpfd_pkg::ST_NEED_MORE;
                    end else begin
                        status = lpfd_pkg::ST_READY;
                    end
                end
            end
            lpfd_pkg::CMD_READ: begin
                if (r_fill >= FILL_W'(HDR) &&
                    CMP_W'(r_in_idx) < CMP_W'(r_fill - FILL_W'(HDR)) &&
                    CMP_W'(r_in_idx) < CMP_W'(P_PAYLOAD_MAX)) begin
                    read_ok = 1'b1;
                    rd_en   = 1'b1;
                end
            end
            lpfd_pkg::CMD_CLEAR: begin
                frame_clear = 1'b1;
            end
            default: begin
            end
        endcase
        if (frame_clear) begin
            n_fill = '0;
            n_kind = '0;
            n_len  = '0;
        end
    end

    assign wr_addr = ADDR_W'(r_fill - FILL_W'(HDR));
    assign rd_addr = ADDR_W'(r_in_idx);

    // result fields seen after the beat
    always_comb begin
        n_res.status         = status;
        n_res.read_ok        = read_ok;
        n_res.payload_length = (n_fill >= FILL_W'(HDR)) ? n_len[PLEN_W-1:0] : '0;
        n_res.kind_out       = (n_fill == '0) ? lpfd_pkg::KIND_NONE : n_kind;
    end

    // control and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_kind  <= lpfd_pkg::REQ_KIND_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_kind      <= '0;
            r_len       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_req_kind <= i_cfg_wdata;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_fill      <= n_fill;
                r_kind      <= n_kind;
                r_len       <= n_len;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // beat payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd  <= i_in.cmd;
            r_in_data <= i_in.data_in;
            r_in_idx  <= i_in.read_index;
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    // payload bytes
    lpfd_store #(
        .P_DEPTH  (P_PAYLOAD_MAX),
        .P_ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && adv),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_in_data),
        .i_rd_en   (rd_en && adv),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output channel
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_res.status;
    assign o_out.read_ok        = r_res.read_ok;
    assign o_out.data_out       = r_res.read_ok ? rd_data : '0;
    assign o_out.payload_length = r_res.payload_length;
    assign o_out.kind_out       = r_res.kind_out;

    // checks
    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(LIMIT), "fill count past limit")
    `ASSERT_IMPLY(a_len_bound, i_clk, i_rst_n, r_fill >= FILL_W'(HDR), r_len <= LEN_W'(P_PAYLOAD_MAX), "held length above maximum")
    `ASSERT_IMPLY(a_empty_frame, i_clk, i_rst_n, r_fill == '0, r_kind == '0 && r_len == '0, "empty frame keeps kind or length")
    `ASSERT_IMPLY(a_read_status, i_clk, i_rst_n, r_out_valid && r_res.read_ok, r_res.status == lpfd_pkg::ST_DONE, "read flag on a push result")
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid, "waiting beat lost")

endmodule
